>>> sv/mqf_pkg.sv
// shared types, codes and defaults for the multi-queue fifo bank
`timescale 1ns / 1ps
`default_nettype none

package mqf_pkg;

	// default geometry
	localparam int QUEUE_COUNT_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	// request actions
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic [15:0] LOST_MAX = 16'hffff;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  queue_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_data;
		logic [15:0] lost_count;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
		logic respond;
	} cmd_t;

endpackage

`default_nettype wire

>>> sv/mqf_ctrl.sv
// sequencing controller for the multi-queue fifo bank
`timescale 1ns / 1ps
`default_nettype none

module mqf_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	output logic              done,
	output mqf_pkg::cmd_t     cmd
);
	import mqf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC);
	assign cmd.respond = (state_q == S_RESP);

endmodule

`default_nettype wire

>>> sv/mqf_datapath.sv
// queue pointers, counters, word store and result registers
`timescale 1ns / 1ps
`default_nettype none

module mqf_datapath #(
	parameter int QUEUE_COUNT = mqf_pkg::QUEUE_COUNT_DEF,
	parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mqf_pkg::cmd_t cmd,
	input  wire mqf_pkg::req_t request,
	output mqf_pkg::rsp_t     result
);
	import mqf_pkg::*;

	localparam int QW        = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	req_t req_q;

	logic [PW-1:0] head_q [QUEUE_COUNT];
	logic [PW-1:0] tail_q [QUEUE_COUNT];
	logic [CW-1:0] fill_q [QUEUE_COUNT];
	logic [15:0]   lost_q [QUEUE_COUNT];

	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] rd_word_q;

	logic [1:0]  status_q;
	logic [15:0] lost_out_q;
	logic        rd_ok_q;

	logic          idx_ok;
	logic [QW-1:0] q;
	logic [PW-1:0] head_cur, tail_cur;
	logic [CW-1:0] fill_cur;
	logic [15:0]   lost_cur, lost_sat;
	logic          rd_go, wr_go;
	logic [1:0]    status_nxt;
	logic [15:0]   lost_nxt;
	logic [AW-1:0] base_addr, rd_addr, wr_addr;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
	end

	assign idx_ok   = ({1'b0, req_q.queue_index} < 4'(QUEUE_COUNT));
	assign q        = req_q.queue_index[QW-1:0];
	assign head_cur = head_q[q];
	assign tail_cur = tail_q[q];
	assign fill_cur = fill_q[q];
	assign lost_cur = lost_q[q];
	assign lost_sat = (lost_cur == LOST_MAX) ? lost_cur : lost_cur + 16'd1;

	assign base_addr = AW'(q) * AW'(QUEUE_DEPTH);
	assign rd_addr   = base_addr + AW'(head_cur);
	assign wr_addr   = base_addr + AW'(tail_cur);

	always_comb begin
		rd_go      = 1'b0;
		wr_go      = 1'b0;
		status_nxt = ST_OK;
		lost_nxt   = lost_cur;
		if (!idx_ok) begin
			status_nxt = ST_BAD_INDEX;
			lost_nxt   = '0;
		end else begin
			unique case (req_q.action)
				ACT_CLEAR: begin
					lost_nxt = '0;
				end
				ACT_READ: begin
					if (fill_cur == '0) begin
						status_nxt = ST_EMPTY;
					end else begin
						rd_go = 1'b1;
					end
				end
				ACT_WRITE: begin
					if (fill_cur == CW'(QUEUE_DEPTH)) begin
						status_nxt = ST_FULL;
						lost_nxt   = lost_sat;
					end else begin
						wr_go = 1'b1;
					end
				end
				default: begin
					lost_nxt = lost_cur;
				end
			endcase
		end
	end

	// per-queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
				lost_q[i] <= '0;
			end
		end else if (cmd.execute && idx_ok) begin
			if (req_q.action == ACT_CLEAR) begin
				head_q[q] <= '0;
				tail_q[q] <= '0;
				fill_q[q] <= '0;
				lost_q[q] <= '0;
			end
			if (rd_go) begin
				head_q[q] <= (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);
				fill_q[q] <= fill_cur - CW'(1);
			end
			if (wr_go) begin
				tail_q[q] <= (tail_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PW'(1);
				fill_q[q] <= fill_cur + CW'(1);
			end
			if (req_q.action == ACT_WRITE && !wr_go) begin
				lost_q[q] <= lost_sat;
			end
		end
	end

	// word store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.execute && wr_go) begin
			mem[wr_addr] <= req_q.write_data;
		end
		if (cmd.execute && rd_go) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q   <= status_nxt;
			lost_out_q <= lost_nxt;
			rd_ok_q    <= rd_go;
		end
	end

	assign result.status     = status_q;
	assign result.read_data  = (cmd.respond && rd_ok_q) ? rd_word_q : '0;
	assign result.lost_count = lost_out_q;

endmodule

`default_nettype wire

>>> sv/multi_queue_fifo_unit.sv
// top level of the multi-queue fifo bank
`timescale 1ns / 1ps
`default_nettype none

// bank of QUEUE_COUNT circular fifos of 32-bit words, QUEUE_DEPTH words each.
// a request is taken when start is high and busy is low; it clears, reads or
// writes one queue. a transaction passes through the cycle in which it is
// accepted, an execute cycle that updates the queue pointers and counters
// and does the registered read of the word store at its closing edge, and the
// cycle in which done is high and the result stands on result. busy rises at
// the accepting edge and stays high until the result cycle ends, so a new
// request is taken only once the last result cycle is over. the receiver
// cannot stall: done and result are valid for exactly one cycle and must be
// captured then. a write to a full queue returns full and bumps that queue's
// saturating lost counter; a read from an empty queue returns empty with
// read_data zero; a queue index at or above QUEUE_COUNT returns bad index and
// changes nothing. stored words are not cleared at reset or by a clear
// action, only the pointers and counters are.
module multi_queue_fifo_unit #(
	parameter int QUEUE_COUNT = mqf_pkg::QUEUE_COUNT_DEF,
	parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire mqf_pkg::req_t request,
	output logic               done,
	output mqf_pkg::rsp_t      result
);
	import mqf_pkg::*;

	cmd_t cmd;

	// sequencing: idle, execute, respond
	mqf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// pointers, counters, word store and result registers
	mqf_datapath #(
		.QUEUE_COUNT (QUEUE_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

	// an accepted transaction answers after the execute state, in the respond state
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction did not answer in time");

	// after a result the block is ready again
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding execute");

	// rejected index leaves zero payload
	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_BAD_INDEX) |->
		(result.lost_count == 16'd0 && result.read_data == 32'd0))
		else $error("bad index result carries data");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the multi-queue fifo bank with a cycle-free mirror of the queues
`timescale 1ns / 1ps

module testbench;
	import mqf_pkg::*;

	// geometry of the instance under test, left at the package defaults
	localparam int QC = QUEUE_COUNT_DEF;
	localparam int QD = QUEUE_DEPTH_DEF;
	localparam int PTR_W = $clog2(QD);
	localparam int FILL_W = $clog2(QD + 1);

	// action code 3 has no meaning in the block and must be ignored by it
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// a run of rejected writes on one full queue to grow its lost counter
	localparam int REJECT_WRITES = 40;

	// sender idle rates, in percent of free cycles, for the three idling phases
	localparam int unsigned IDLE_LIGHT = 22;
	localparam int unsigned IDLE_HEAVY = 75;
	localparam int unsigned IDLE_NONE = 0;

	typedef struct {
		req_t        req;
		int unsigned idle_pct;
	} send_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	multi_queue_fifo_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// requests not yet offered, and answers owed by the block in acceptance order
	send_item_t requests_to_send[$];
	rsp_t replies_due[$];

	// mirror of the queue bank as the block should hold it
	logic [31:0]       mirror_words [QC][QD];
	logic [PTR_W-1:0]  mirror_head [QC];
	logic [PTR_W-1:0]  mirror_tail [QC];
	logic [FILL_W-1:0] mirror_fill [QC];
	logic [15:0]       mirror_lost [QC];

	// tallies for the closing summary
	int mismatches = 0;
	int seen_ok = 0;
	int seen_bad_index = 0;
	int seen_full = 0;
	int seen_empty = 0;
	logic [15:0] peak_lost = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	// runaway guard: the slowest legal run is a small fraction of this
	initial begin
		#(10_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// applies one request to the mirror and returns the answer the block owes for it
	function automatic rsp_t fifo_bank_answer(req_t r);
		rsp_t a;
		int q;
		a = '0;
		a.status = ST_OK;
		q = int'(r.queue_index);
		if (q >= QC) begin
			// bad index: nothing moves, counter field reads zero
			a.status = ST_BAD_INDEX;
		end else begin
			case (r.action)
				ACT_CLEAR: begin
					// stored words stay, only pointers and counters go back to zero
					mirror_head[q] = '0;
					mirror_tail[q] = '0;
					mirror_fill[q] = '0;
					mirror_lost[q] = '0;
				end
				ACT_READ: begin
					if (mirror_fill[q] == 0) begin
						a.status = ST_EMPTY;
					end else begin
						a.read_data = mirror_words[q][mirror_head[q]];
						mirror_head[q] = (mirror_head[q] == QD - 1) ? '0 : mirror_head[q] + 1'b1;
						mirror_fill[q] = mirror_fill[q] - 1'b1;
					end
				end
				ACT_WRITE: begin
					if (mirror_fill[q] == QD) begin
						// rejected write, counter sticks at its maximum
						a.status = ST_FULL;
						if (mirror_lost[q] != LOST_MAX)
							mirror_lost[q] = mirror_lost[q] + 1'b1;
					end else begin
						mirror_words[q][mirror_tail[q]] = r.write_data;
						mirror_tail[q] = (mirror_tail[q] == QD - 1) ? '0 : mirror_tail[q] + 1'b1;
						mirror_fill[q] = mirror_fill[q] + 1'b1;
					end
				end
				default: begin
					// unused code: state untouched, counter still reported
				end
			endcase
			a.lost_count = mirror_lost[q];
		end
		return a;
	endfunction

	function automatic void add_item(logic [1:0] act, logic [2:0] qi, logic [31:0] data,
			int unsigned idle);
		send_item_t it;
		it.req.action = act;
		it.req.queue_index = qi;
		it.req.write_data = data;
		it.idle_pct = idle;
		requests_to_send.push_back(it);
	endfunction

	// data words lean toward the all-zero and all-one corners now and then
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// random traffic in bursts: each burst favors one queue and either filling or
	// draining it, so queues regularly run full and empty and pointers wrap
	function automatic void add_random_items(int n, int unsigned idle);
		int focus;
		int write_pct;
		int r;
		logic [1:0] act;
		logic [2:0] qi;
		focus = 0;
		write_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0) begin
				focus = $urandom_range(QC - 1);
				write_pct = $urandom_range(1) ? 78 : 22;
			end
			r = $urandom_range(99);
			if (r < 4) begin
				// out-of-range queue with any action code
				act = 2'($urandom_range(3));
				qi = 3'($urandom_range(7, QC));
			end else if (r < 7) begin
				act = ACT_CLEAR;
				qi = 3'($urandom_range(QC - 1));
			end else if (r < 9) begin
				act = ACT_UNUSED;
				qi = 3'($urandom_range(QC - 1));
			end else begin
				qi = ($urandom_range(9) < 7) ? 3'(focus) : 3'($urandom_range(QC - 1));
				act = ($urandom_range(99) < write_pct) ? ACT_WRITE : ACT_READ;
			end
			add_item(act, qi, pick_word(), idle);
		end
	endfunction

	// compares one field of a result and reports the difference
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// driver: a transaction is taken at an edge where start is high and busy is
	// low; start then either carries the next request or drops for an idle cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				replies_due.push_back(fifo_bank_answer(request));
			if (!start || !busy) begin
				if (requests_to_send.size() != 0 &&
						$urandom_range(99) >= requests_to_send[0].idle_pct) begin
					request <= requests_to_send.pop_front().req;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: done marks a one-cycle result that must be taken at this edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual %h", $time, result);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("read_data", want.read_data, result.read_data);
				check_field("lost_count", 32'(want.lost_count), 32'(result.lost_count));
				case (result.status)
					ST_OK: seen_ok++;
					ST_BAD_INDEX: seen_bad_index++;
					ST_FULL: seen_full++;
					default: seen_empty++;
				endcase
				if (result.lost_count > peak_lost)
					peak_lost = result.lost_count;
			end
		end
	end

	initial begin
		for (int q = 0; q < QC; q++) begin
			mirror_head[q] = '0;
			mirror_tail[q] = '0;
			mirror_fill[q] = '0;
			mirror_lost[q] = '0;
			for (int k = 0; k < QD; k++)
				mirror_words[q][k] = '0;
		end

		// directed: data corners, read past the end, bad indexes, fill to full,
		// rejected write, unused action with a nonzero counter, clear, read after clear
		add_item(ACT_WRITE, 3'd0, '0, IDLE_LIGHT);
		add_item(ACT_WRITE, 3'd0, '1, IDLE_LIGHT);
		add_item(ACT_READ, 3'd0, '0, IDLE_LIGHT);
		add_item(ACT_READ, 3'd0, '0, IDLE_LIGHT);
		add_item(ACT_READ, 3'd0, '0, IDLE_LIGHT);
		add_item(ACT_WRITE, 3'd4, '1, IDLE_LIGHT);
		add_item(ACT_READ, 3'd7, '0, IDLE_LIGHT);
		for (int k = 0; k < QD; k++)
			add_item(ACT_WRITE, 3'd2, pick_word(), IDLE_LIGHT);
		add_item(ACT_WRITE, 3'd2, pick_word(), IDLE_LIGHT);
		add_item(ACT_UNUSED, 3'd2, '0, IDLE_LIGHT);
		add_item(ACT_CLEAR, 3'd2, '0, IDLE_LIGHT);
		add_item(ACT_READ, 3'd2, '0, IDLE_LIGHT);

		// random traffic through the three idling phases
		add_random_items(600, IDLE_LIGHT);
		add_random_items(600, IDLE_HEAVY);
		add_random_items(480, IDLE_NONE);

		// fill one queue, pile rejected writes on it, then read and clear it
		add_item(ACT_CLEAR, 3'd1, '0, IDLE_NONE);
		for (int k = 0; k < QD; k++)
			add_item(ACT_WRITE, 3'd1, pick_word(), IDLE_NONE);
		for (int k = 0; k < REJECT_WRITES; k++)
			add_item(ACT_WRITE, 3'd1, pick_word(), IDLE_NONE);
		add_item(ACT_UNUSED, 3'd1, '0, IDLE_NONE);
		add_item(ACT_READ, 3'd1, '0, IDLE_NONE);
		add_item(ACT_CLEAR, 3'd1, '0, IDLE_NONE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything offered, taken and answered
		while (requests_to_send.size() != 0 || start || replies_due.size() != 0)
			@(posedge clk);
		// keep the clock running to catch any stray result
		repeat (10) @(posedge clk);

		$display("checked %0d results: %0d ok, %0d bad index, %0d full, %0d empty",
			seen_ok + seen_bad_index + seen_full + seen_empty,
			seen_ok, seen_bad_index, seen_full, seen_empty);
		$display("highest lost count seen %0d, field mismatches %0d", peak_lost, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
